// ----- rtl/sbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int VAR_COUNT_DEF   = 256;
  localparam int MAX_LOOPS_DEF   = 8;

  localparam int KIND_W = 6;
  localparam int OB_W   = 8;
  localparam int PC_W   = 16;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_STR, OP_PUSH_NUM, OP_PUSH_GLB, OP_PUSH_LOC, OP_POP_GLB, OP_POP_LOC,
    OP_INC_GLB, OP_DEC_GLB, OP_INC_LOC, OP_DEC_LOC, OP_ENTER, OP_LEAVE, OP_PUSH_RET,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NEG, OP_LAND, OP_LOR, OP_LNOT,
    OP_AND, OP_OR, OP_XOR, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
    OP_GOTO, OP_GOSUB, OP_RETURN, OP_RETI, OP_FOR, OP_NEXT, OP_IF,
    OP_ON_GOTO, OP_ON_GOSUB, OP_PARAM, OP_PUSH_PARAM, OP_XCALL, OP_BREAK, OP_END
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    RS_CONT, RS_END, RS_ERROR, RS_BREAK, RS_RETI, RS_XCALL
  } res_status_t;

  typedef enum logic [2:0] {
    AS_R1, AS_R2, AS_R3, AS_WR, AS_TOP
  } asel_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A1, S_R1, S_R2, S_R3, S_LAT, S_DIV, S_COMMIT,
    S_TOPA, S_TOPR, S_TOPL
  } ctrl_state_t;

  typedef struct packed {
    logic  load;
    logic  clr;
    asel_t asel;
    logic  rd_first;
    logic  rd_stk;
    logic  lat_a;
    logic  lat_b;
    logic  lat_c;
    logic  div_start;
    logic  commit;
    logic  top_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_div;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/sbe_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sbe_modred.sv -----
`timescale 1ns / 1ps
`default_nettype none

// value modulo a constant: reciprocal quotient registered, then remainder
module sbe_modred #(
  parameter int IN_W    = 16,
  parameter int DIVISOR = 64
) (
  input  wire logic                       clk,
  input  wire logic [IN_W-1:0]            v,
  output logic      [$clog2(DIVISOR)-1:0] slot
);

  localparam int OUT_W = $clog2(DIVISOR);
  localparam int SH    = IN_W + OUT_W;
  localparam longint unsigned RECIP = ((longint'(1) << SH) + DIVISOR - 1) / DIVISOR;

  logic [IN_W+SH-1:0] prod;
  logic [IN_W-1:0]    q_r;
  logic [IN_W-1:0]    v_r;
  logic [SH-1:0]      rem_w;

  assign prod = IN_W'(0) + (SH'(0) + {SH'(0), v}) * (IN_W+SH)'(RECIP);

  always_ff @(posedge clk) begin
    q_r <= prod[IN_W+SH-1:SH];
    v_r <= v;
  end

  assign rem_w = SH'(v_r) - SH'(q_r) * SH'(DIVISOR);
  assign slot  = rem_w[OUT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/sbe_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// signed truncating divide, one quotient bit per cycle
module sbe_div
  import sbe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   busy,
  output logic      [DATA_W-1:0] quo,
  output logic      [DATA_W-1:0] rem
);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] r_r;
  logic [DATA_W-1:0] ud;
  logic [5:0]        cnt;
  logic              neg_q;
  logic              neg_r;
  logic              zero;
  logic [DATA_W:0]   trial;

  assign trial = {r_r, q_r[DATA_W-1]} - {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(DATA_W);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r <= dividend[DATA_W-1];
      zero  <= (divisor == '0);
      q_r   <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      ud    <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      r_r   <= '0;
    end else if (busy) begin
      if (!trial[DATA_W]) begin
        r_r <= trial[DATA_W-1:0];
        q_r <= {q_r[DATA_W-2:0], 1'b1};
      end else begin
        r_r <= {r_r[DATA_W-2:0], q_r[DATA_W-1]};
        q_r <= {q_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quo = zero ? '0 : (neg_q ? (DATA_W'(0) - q_r) : q_r);
  assign rem = zero ? '0 : (neg_r ? (DATA_W'(0) - r_r) : r_r);

endmodule

`default_nettype wire

// ----- rtl/sbe_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbe_ctrl
  import sbe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_A1;
        end
      end
      S_A1: begin
        cmd.asel   = AS_R1;
        state_next = S_R1;
      end
      S_R1: begin
        cmd.rd_first = 1'b1;
        cmd.asel     = AS_R2;
        state_next   = S_R2;
      end
      S_R2: begin
        cmd.rd_stk = 1'b1;
        cmd.lat_a  = 1'b1;
        cmd.asel   = AS_R3;
        state_next = S_R3;
      end
      S_R3: begin
        cmd.rd_stk = 1'b1;
        cmd.lat_b  = 1'b1;
        cmd.asel   = AS_WR;
        state_next = S_LAT;
      end
      S_LAT: begin
        cmd.lat_c = 1'b1;
        cmd.asel  = AS_WR;
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DIV: begin
        cmd.asel = AS_WR;
        if (stat.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        cmd.asel   = AS_WR;
        state_next = S_TOPA;
      end
      S_TOPA: begin
        cmd.asel   = AS_TOP;
        state_next = S_TOPR;
      end
      S_TOPR: begin
        cmd.rd_stk = 1'b1;
        cmd.asel   = AS_TOP;
        state_next = S_TOPL;
      end
      S_TOPL: begin
        cmd.asel = AS_TOP;
        if (!stat.out_busy) begin
          cmd.top_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sbe_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbe_datapath
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VAR_COUNT   = VAR_COUNT_DEF,
  parameter int MAX_LOOPS   = MAX_LOOPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [OB_W-1:0]   in_ob,
  input  wire logic [PC_W-1:0]   in_tgt,
  input  wire logic [DATA_W-1:0] in_imm,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [STAT_W-1:0] out_status,
  output logic      [PC_W-1:0]   out_pc,
  output logic      [DATA_W-1:0] out_top,
  output logic      [OB_W-1:0]   out_call
);

  localparam int SLOT_W = $clog2(STACK_DEPTH);
  localparam int GIDX_W = $clog2(VAR_COUNT);
  localparam int CLR_N  = (STACK_DEPTH > VAR_COUNT) ? STACK_DEPTH : VAR_COUNT;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam logic [PC_W-1:0] SD16 = PC_W'(STACK_DEPTH);
  localparam logic [7:0]      ML8  = 8'(MAX_LOOPS);

  // architectural state
  logic [PC_W-1:0]   pc, sp, fp;
  logic [7:0]        ap, ld;
  logic [DATA_W-1:0] rr;

  // current word
  op_t               kind_r;
  logic [OB_W-1:0]   ob_r;
  logic [PC_W-1:0]   tgt_r;
  logic [DATA_W-1:0] imm_r;
  logic [DATA_W-1:0] va, vb, vc, vg, varg;
  res_status_t       st_r;
  logic [OB_W-1:0]   call_r;

  logic [CLR_W-1:0]  cnt;

  // addressing
  logic [PC_W-1:0]   loc, wa, sa;
  logic [SLOT_W-1:0] slot, aslot;
  logic [GIDX_W-1:0] gslot;
  logic [7:0]        aaddr;
  logic              is_leave;

  // memories
  logic              stk_we, stk_re, glb_we, arg_we;
  logic [SLOT_W-1:0] stk_waddr, arg_waddr;
  logic [GIDX_W-1:0] glb_waddr;
  logic [DATA_W-1:0] stk_wdata, glb_wdata, arg_wdata;
  logic [DATA_W-1:0] stk_rd, glb_rd, arg_rd;

  // divider
  logic              div_busy;
  logic [DATA_W-1:0] div_q, div_r;

  // step result
  logic              wr_stk, wr_glb, wr_arg;
  logic [DATA_W-1:0] stk_wd, glb_wd, arg_wd, bin_res, nsum;
  logic [PC_W-1:0]   sp_n, fp_n, pc_n, pc2, ob3, sel, sel3, sp1;
  logic [7:0]        ap_n, ld_n, ld_inc;
  logic [DATA_W-1:0] rr_n;
  res_status_t       st_n;
  logic [OB_W-1:0]   call_n;
  logic              loop_on;

  assign is_leave = (kind_r == OP_LEAVE);
  assign loc      = fp + PC_W'(ob_r);

  always_comb begin
    case (kind_r) inside
      OP_POP_LOC, OP_INC_LOC, OP_DEC_LOC: wa = loc;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LAND, OP_LOR, OP_AND, OP_OR, OP_XOR,
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: wa = sp - 16'd2;
      OP_NEG, OP_LNOT, OP_ON_GOSUB: wa = sp - 16'd1;
      default: wa = sp;
    endcase
  end

  always_comb begin
    unique case (cmd.asel)
      AS_R1:   sa = sp - 16'd1;
      AS_R2:   sa = is_leave ? fp - 16'd1 : sp - 16'd2;
      AS_R3:   sa = is_leave ? fp - 16'd2 : loc;
      AS_WR:   sa = wa;
      AS_TOP:  sa = sp - 16'd1;
      default: sa = sp;
    endcase
  end

  assign aaddr = (kind_r == OP_PARAM) ? ap - 8'd1 : ap;

  sbe_modred #(.IN_W(PC_W), .DIVISOR(STACK_DEPTH)) u_stk_red (
    .clk(clk), .v(sa), .slot(slot)
  );
  sbe_modred #(.IN_W(8), .DIVISOR(STACK_DEPTH)) u_arg_red (
    .clk(clk), .v(aaddr), .slot(aslot)
  );
  sbe_modred #(.IN_W(OB_W), .DIVISOR(VAR_COUNT)) u_glb_red (
    .clk(clk), .v(ob_r), .slot(gslot)
  );

  // power-up clearing sweep over all stores
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr) begin
      cnt <= cnt + CLR_W'(1);
    end
  end

  assign stat.clr_done = (cnt == CLR_W'(CLR_N - 1));
  assign stat.is_div   = (kind_r == OP_DIV) || (kind_r == OP_MOD);
  assign stat.div_done = !div_busy;
  assign stat.out_busy = out_valid && !out_ready;

  always_comb begin
    if (cmd.clr) begin
      stk_we    = ({1'b0, cnt} < (CLR_W+1)'(STACK_DEPTH));
      stk_waddr = cnt[SLOT_W-1:0];
      stk_wdata = '0;
      arg_we    = stk_we;
      arg_waddr = cnt[SLOT_W-1:0];
      arg_wdata = '0;
      glb_we    = ({1'b0, cnt} < (CLR_W+1)'(VAR_COUNT));
      glb_waddr = cnt[GIDX_W-1:0];
      glb_wdata = '0;
    end else begin
      stk_we    = cmd.commit && wr_stk;
      stk_waddr = slot;
      stk_wdata = stk_wd;
      arg_we    = cmd.commit && wr_arg;
      arg_waddr = aslot;
      arg_wdata = arg_wd;
      glb_we    = cmd.commit && wr_glb;
      glb_waddr = gslot;
      glb_wdata = glb_wd;
    end
  end

  assign stk_re = cmd.rd_first || cmd.rd_stk;

  sbe_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(slot), .rdata(stk_rd)
  );
  sbe_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_arg_ram (
    .clk(clk), .we(arg_we), .waddr(arg_waddr), .wdata(arg_wdata),
    .re(cmd.rd_first), .raddr(aslot), .rdata(arg_rd)
  );
  sbe_ram #(.WIDTH(DATA_W), .DEPTH(VAR_COUNT)) u_glb_ram (
    .clk(clk), .we(glb_we), .waddr(glb_waddr), .wdata(glb_wdata),
    .re(cmd.rd_first), .raddr(gslot), .rdata(glb_rd)
  );

  sbe_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(vb), .divisor(va),
    .busy(div_busy), .quo(div_q), .rem(div_r)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= op_t'(in_kind);
      ob_r   <= in_ob;
      tgt_r  <= in_tgt;
      imm_r  <= in_imm;
    end
    if (cmd.lat_a) begin
      va   <= stk_rd;
      vg   <= glb_rd;
      varg <= arg_rd;
    end
    if (cmd.lat_b) begin
      vb <= stk_rd;
    end
    if (cmd.lat_c) begin
      vc <= stk_rd;
    end
  end

  // binary operators: a is the top, b the entry below the top
  always_comb begin
    case (kind_r)
      OP_ADD:  bin_res = vb + va;
      OP_SUB:  bin_res = vb - va;
      OP_MUL:  bin_res = vb * va;
      OP_DIV:  bin_res = div_q;
      OP_MOD:  bin_res = div_r;
      OP_LAND: bin_res = DATA_W'((vb != '0) && (va != '0));
      OP_LOR:  bin_res = DATA_W'((vb != '0) || (va != '0));
      OP_AND:  bin_res = vb & va;
      OP_OR:   bin_res = vb | va;
      OP_XOR:  bin_res = vb ^ va;
      OP_EQ:   bin_res = DATA_W'(vb == va);
      OP_NE:   bin_res = DATA_W'(vb != va);
      OP_LT:   bin_res = DATA_W'($signed(vb) < $signed(va));
      OP_LE:   bin_res = DATA_W'($signed(vb) <= $signed(va));
      OP_GT:   bin_res = DATA_W'($signed(vb) > $signed(va));
      default: bin_res = DATA_W'($signed(vb) >= $signed(va));
    endcase
  end

  assign nsum    = vg + va;
  assign loop_on = ($signed(va) < 0 && $signed(nsum) >= $signed(vb))
                || ($signed(va) >= 0 && $signed(nsum) <= $signed(vb));
  assign ld_inc  = ld + 8'd1;
  assign pc2     = pc + 16'd2;
  assign ob3     = PC_W'({ob_r, 1'b0}) + PC_W'(ob_r);
  assign sel     = va[PC_W-1:0];
  assign sel3    = ((sel - 16'd1) << 1) + (sel - 16'd1);
  assign sp1     = sp - 16'd1;

  always_comb begin
    wr_stk = 1'b0;
    wr_glb = 1'b0;
    wr_arg = 1'b0;
    stk_wd = '0;
    glb_wd = '0;
    arg_wd = '0;
    sp_n   = sp;
    fp_n   = fp;
    pc_n   = pc;
    ap_n   = ap;
    ld_n   = ld;
    rr_n   = rr;
    st_n   = RS_CONT;
    call_n = '0;
    unique case (kind_r)
      OP_PUSH_STR: begin
        wr_stk = 1'b1; stk_wd = DATA_W'(pc) + 32'd2;
        sp_n = sp + 16'd1; pc_n = pc + PC_W'(ob_r) + 16'd2;
      end
      OP_PUSH_NUM: begin
        wr_stk = 1'b1; stk_wd = imm_r; sp_n = sp + 16'd1; pc_n = pc + 16'd5;
      end
      OP_PUSH_GLB: begin
        wr_stk = 1'b1; stk_wd = vg; sp_n = sp + 16'd1; pc_n = pc2;
      end
      OP_PUSH_LOC: begin
        wr_stk = 1'b1; stk_wd = vc; sp_n = sp + 16'd1; pc_n = pc2;
      end
      OP_POP_GLB: begin
        wr_glb = 1'b1; glb_wd = va; sp_n = sp1; pc_n = pc2;
      end
      OP_POP_LOC: begin
        wr_stk = 1'b1; stk_wd = va; sp_n = sp1; pc_n = pc2;
      end
      OP_INC_GLB: begin
        wr_glb = 1'b1; glb_wd = vg + 32'd1; pc_n = pc2;
      end
      OP_DEC_GLB: begin
        wr_glb = 1'b1; glb_wd = vg - 32'd1; pc_n = pc2;
      end
      OP_INC_LOC: begin
        wr_stk = 1'b1; stk_wd = vc + 32'd1; pc_n = pc2;
      end
      OP_DEC_LOC: begin
        wr_stk = 1'b1; stk_wd = vc - 32'd1; pc_n = pc2;
      end
      OP_ENTER: begin
        wr_stk = 1'b1; stk_wd = DATA_W'(fp);
        fp_n = sp + 16'd1; sp_n = sp + 16'd1 + PC_W'(ob_r); pc_n = pc2;
      end
      OP_LEAVE: begin
        rr_n = (sp > fp) ? va : rr;
        sp_n = fp - 16'd2;
        fp_n = vb[PC_W-1:0];
        pc_n = vc[PC_W-1:0];
      end
      OP_PUSH_RET: begin
        wr_stk = 1'b1; stk_wd = rr; sp_n = sp + 16'd1; pc_n = pc + 16'd1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LAND, OP_LOR, OP_AND, OP_OR, OP_XOR,
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
        wr_stk = 1'b1; stk_wd = bin_res; sp_n = sp1; pc_n = pc + 16'd1;
      end
      OP_NEG: begin
        wr_stk = 1'b1; stk_wd = DATA_W'(0) - va; pc_n = pc + 16'd1;
      end
      OP_LNOT: begin
        wr_stk = 1'b1; stk_wd = DATA_W'(va == '0); pc_n = pc + 16'd1;
      end
      OP_GOTO: pc_n = tgt_r;
      OP_GOSUB: begin
        if (sp < SD16) begin
          wr_stk = 1'b1; stk_wd = DATA_W'(pc) + 32'd3;
          sp_n = sp + 16'd1; pc_n = tgt_r;
        end else begin
          st_n = RS_ERROR;
        end
      end
      OP_RETURN: begin
        sp_n = sp1; pc_n = va[PC_W-1:0];
      end
      OP_RETI: begin
        sp_n = sp1; pc_n = va[PC_W-1:0]; st_n = RS_RETI;
      end
      OP_FOR: begin
        ld_n = ld_inc;
        if (ld_inc > ML8) begin
          st_n = RS_ERROR;
        end else begin
          pc_n = pc + 16'd1;
        end
      end
      OP_NEXT: begin
        wr_glb = 1'b1; glb_wd = nsum;
        if (loop_on) begin
          pc_n = tgt_r;
        end else begin
          pc_n = pc + 16'd4; sp_n = sp - 16'd2; ld_n = ld - 8'd1;
        end
      end
      OP_IF: begin
        sp_n = sp1; pc_n = (va == '0) ? tgt_r : pc + 16'd3;
      end
      OP_ON_GOTO, OP_ON_GOSUB: begin
        sp_n = sp1;
        if (sel == '0 || sel > PC_W'(ob_r)) begin
          pc_n = pc2 + ob3;
        end else if (kind_r == OP_ON_GOTO) begin
          pc_n = pc2 + sel3;
        end else if (sp1 < SD16) begin
          wr_stk = 1'b1; stk_wd = DATA_W'(pc2) + DATA_W'(ob3);
          sp_n = sp; pc_n = pc2 + sel3;
        end else begin
          pc_n = pc2; st_n = RS_ERROR;
        end
      end
      OP_PARAM: begin
        wr_stk = 1'b1; sp_n = sp + 16'd1; pc_n = pc + 16'd1;
        if (ap != '0) begin
          stk_wd = varg; ap_n = ap - 8'd1;
        end
      end
      OP_PUSH_PARAM: begin
        wr_arg = 1'b1; arg_wd = va; ap_n = ap + 8'd1; sp_n = sp1; pc_n = pc + 16'd1;
      end
      OP_XCALL: begin
        pc_n = pc2; st_n = RS_XCALL; call_n = ob_r;
      end
      OP_BREAK: begin
        wr_arg = 1'b1; arg_wd = DATA_W'(tgt_r); ap_n = ap + 8'd1;
        pc_n = pc + 16'd3; st_n = RS_BREAK;
      end
      OP_END: st_n = RS_END;
      default: st_n = RS_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 16'd1;
      sp <= '0;
      fp <= '0;
      ap <= '0;
      ld <= '0;
      rr <= '0;
    end else if (cmd.commit) begin
      pc <= pc_n;
      sp <= sp_n;
      fp <= fp_n;
      ap <= ap_n;
      ld <= ld_n;
      rr <= rr_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      st_r   <= st_n;
      call_r <= call_n;
    end
    if (cmd.top_load) begin
      out_top    <= stk_rd;
      out_pc     <= pc;
      out_status <= st_r;
      out_call   <= call_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.top_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stack_bytecode_execute_unit.sv -----
// Stack bytecode execute unit: runs one pre-decoded interpreter instruction
// per input word and returns the next program counter, a status, the new
// stack top and an external call number.
// Input channel s_axis: tuser carries the opcode, tdata the operand byte,
// jump target and immediate. Output channel m_axis: tuser carries the
// status, tdata the next pc, stack top and call number.
// Each word runs through a fixed sequence: address reduction, three operand
// stack reads plus one global and one parameter read, a commit cycle with
// at most one write per store, and a read of the new top. Divide and modulo
// also wait for the one-bit-per-cycle divider before the commit. The unit
// takes the next word only once the current one has loaded its result.
// After reset the unit sweeps all stores to zero, with tready low.
// A finished result is held in an output register; the next word is taken
// meanwhile and waits in its last cycle only while a previous result is
// still not taken.
`timescale 1ns / 1ps
`default_nettype none

module stack_bytecode_execute_unit
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VAR_COUNT   = VAR_COUNT_DEF,
  parameter int MAX_LOOPS   = MAX_LOOPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // operand_byte, target, immediate
  input  wire logic [KIND_W-1:0]      s_axis_tuser,  // kind
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // next_pc, top_value, call_number
  output logic      [STAT_W-1:0]      m_axis_tuser   // status
);

  cmd_t              cmd;
  stat_t             stat;
  logic [PC_W-1:0]   o_pc;
  logic [DATA_W-1:0] o_top;
  logic [OB_W-1:0]   o_call;

  sbe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  sbe_datapath #(
    .STACK_DEPTH(STACK_DEPTH), .VAR_COUNT(VAR_COUNT), .MAX_LOOPS(MAX_LOOPS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_kind(s_axis_tuser),
    .in_ob(s_axis_tdata[7:0]),
    .in_tgt(s_axis_tdata[23:8]),
    .in_imm(s_axis_tdata[55:24]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(m_axis_tuser), .out_pc(o_pc), .out_top(o_top), .out_call(o_call)
  );

  assign m_axis_tdata = {o_call, o_top, o_pc};

endmodule

`default_nettype wire

// ----- dv/sbe_checker.sv -----
`timescale 1ns / 1ps

module sbe_checker
  import sbe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [KIND_W-1:0]      s_axis_tuser,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic [STAT_W-1:0]      m_axis_tuser,
  output int                          fail_count,
  output int                          pending,
  output int                          words_checked
);

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int NVARS = VAR_COUNT_DEF;
  localparam int LOOPS = MAX_LOOPS_DEF;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [15:0]       npc;
    logic [31:0]       top;
    logic [7:0]        call;
  } outcome_t;

  outcome_t   expected_q[$];
  logic [31:0] stk  [DEPTH];
  logic [31:0] glb  [NVARS];
  logic [31:0] args [DEPTH];
  logic [15:0] pc, sp, fp;
  logic [7:0]  ap, nest;
  logic [31:0] retv;

  function automatic int slot(logic [15:0] v);
    return int'(v) % DEPTH;
  endfunction

  function automatic void push_val(logic [31:0] v);
    stk[slot(sp)] = v;
    sp = sp + 16'd1;
  endfunction

  function automatic logic [31:0] pop_val();
    sp = sp - 16'd1;
    return stk[slot(sp)];
  endfunction

  function automatic logic [31:0] alu(op_t k, logic [31:0] a, logic [31:0] b);
    logic signed [31:0] sa, sb;
    sa = a;
    sb = b;
    case (k)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (sb == 0) return 0;
        if (sa == 32'sh80000000 && sb == -1) return a;
        return sa / sb;
      end
      OP_MOD: begin
        if (sb == 0 || sb == -1) return 0;
        return sa % sb;
      end
      OP_LAND: return (a != 0 && b != 0) ? 1 : 0;
      OP_LOR:  return (a != 0 || b != 0) ? 1 : 0;
      OP_AND:  return a & b;
      OP_OR:   return a | b;
      OP_XOR:  return a ^ b;
      OP_EQ:   return (sa == sb) ? 1 : 0;
      OP_NE:   return (sa != sb) ? 1 : 0;
      OP_LT:   return (sa < sb) ? 1 : 0;
      OP_LE:   return (sa <= sb) ? 1 : 0;
      OP_GT:   return (sa > sb) ? 1 : 0;
      default: return (sa >= sb) ? 1 : 0;
    endcase
  endfunction

  function automatic outcome_t execute_word(logic [5:0] kind, logic [7:0] ob,
                                            logic [15:0] tgt, logic [31:0] imm);
    outcome_t r;
    logic [15:0] npc, sel;
    logic [31:0] a, b;
    logic signed [31:0] step, lim, v;
    int g, loc;
    npc = pc;
    r = '0;
    r.status = RS_CONT;
    g = int'(ob) % NVARS;
    loc = slot(fp + {8'd0, ob});
    case (kind)
      OP_PUSH_STR: begin push_val({16'd0, pc} + 32'd2); npc = pc + ob + 16'd2; end
      OP_PUSH_NUM: begin push_val(imm); npc = pc + 16'd5; end
      OP_PUSH_GLB: begin push_val(glb[g]); npc = pc + 16'd2; end
      OP_PUSH_LOC: begin push_val(stk[loc]); npc = pc + 16'd2; end
      OP_POP_GLB:  begin glb[g] = pop_val(); npc = pc + 16'd2; end
      OP_POP_LOC:  begin a = pop_val(); stk[loc] = a; npc = pc + 16'd2; end
      OP_INC_GLB:  begin glb[g] = glb[g] + 1; npc = pc + 16'd2; end
      OP_DEC_GLB:  begin glb[g] = glb[g] - 1; npc = pc + 16'd2; end
      OP_INC_LOC:  begin stk[loc] = stk[loc] + 1; npc = pc + 16'd2; end
      OP_DEC_LOC:  begin stk[loc] = stk[loc] - 1; npc = pc + 16'd2; end
      OP_ENTER: begin
        push_val({16'd0, fp});
        fp = sp;
        sp = sp + {8'd0, ob};
        npc = pc + 16'd2;
      end
      OP_LEAVE: begin
        if (sp > fp) retv = pop_val();
        sp = fp;
        a = pop_val();
        fp = a[15:0];
        a = pop_val();
        npc = a[15:0];
      end
      OP_PUSH_RET: begin push_val(retv); npc = pc + 16'd1; end
      OP_NEG: begin stk[slot(sp - 16'd1)] = 32'd0 - stk[slot(sp - 16'd1)]; npc = pc + 16'd1; end
      OP_LNOT: begin
        stk[slot(sp - 16'd1)] = (stk[slot(sp - 16'd1)] == 0) ? 32'd1 : 32'd0;
        npc = pc + 16'd1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LAND, OP_LOR, OP_AND, OP_OR,
      OP_XOR, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
        b = pop_val();
        stk[slot(sp - 16'd1)] = alu(op_t'(kind), stk[slot(sp - 16'd1)], b);
        npc = pc + 16'd1;
      end
      OP_GOTO: npc = tgt;
      OP_GOSUB: begin
        if (sp < DEPTH) begin
          push_val({16'd0, pc} + 32'd3);
          npc = tgt;
        end else begin
          r.status = RS_ERROR;
        end
      end
      OP_RETURN: begin a = pop_val(); npc = a[15:0]; end
      OP_RETI: begin a = pop_val(); npc = a[15:0]; r.status = RS_RETI; end
      OP_FOR: begin
        nest = nest + 8'd1;
        if (nest > LOOPS) r.status = RS_ERROR;
        else npc = pc + 16'd1;
      end
      OP_NEXT: begin
        step = stk[slot(sp - 16'd1)];
        lim = stk[slot(sp - 16'd2)];
        glb[g] = glb[g] + step;
        v = glb[g];
        if ((step < 0 && v >= lim) || (step >= 0 && v <= lim)) begin
          npc = tgt;
        end else begin
          npc = pc + 16'd4;
          a = pop_val();
          a = pop_val();
          nest = nest - 8'd1;
        end
      end
      OP_IF: begin a = pop_val(); npc = (a == 0) ? tgt : pc + 16'd3; end
      OP_ON_GOTO, OP_ON_GOSUB: begin
        a = pop_val();
        sel = a[15:0];
        npc = pc + 16'd2;
        if (sel == 0 || sel > ob) begin
          npc = npc + 16'(ob * 3);
        end else if (kind == OP_ON_GOTO) begin
          npc = npc + 16'((sel - 1) * 3);
        end else if (sp < DEPTH) begin
          push_val({16'd0, npc} + ob * 3);
          npc = npc + 16'((sel - 1) * 3);
        end else begin
          r.status = RS_ERROR;
        end
      end
      OP_PARAM: begin
        a = 0;
        if (ap > 0) begin
          ap = ap - 8'd1;
          a = args[int'(ap) % DEPTH];
        end
        push_val(a);
        npc = pc + 16'd1;
      end
      OP_PUSH_PARAM: begin
        args[int'(ap) % DEPTH] = pop_val();
        ap = ap + 8'd1;
        npc = pc + 16'd1;
      end
      OP_XCALL: begin npc = pc + 16'd2; r.status = RS_XCALL; r.call = ob; end
      OP_BREAK: begin
        args[int'(ap) % DEPTH] = {16'd0, tgt};
        ap = ap + 8'd1;
        npc = pc + 16'd3;
        r.status = RS_BREAK;
      end
      OP_END: r.status = RS_END;
      default: r.status = RS_ERROR;
    endcase
    pc = npc;
    r.npc = npc;
    r.top = stk[slot(sp - 16'd1)];
    return r;
  endfunction

  initial begin
    pc = 16'd1;
    sp = 0;
    fp = 0;
    ap = 0;
    nest = 0;
    retv = 0;
    foreach (stk[i]) stk[i] = 0;
    foreach (glb[i]) glb[i] = 0;
    foreach (args[i]) args[i] = 0;
    fail_count = 0;
    words_checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(execute_word(s_axis_tuser, s_axis_tdata[7:0],
                                          s_axis_tdata[23:8], s_axis_tdata[55:24]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.npc = m_axis_tdata[15:0];
        got.top = m_axis_tdata[47:16];
        got.call = m_axis_tdata[55:48];
        words_checked <= words_checked + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word status=%0d pc=%h top=%h call=%h",
                   $time, got.status, got.npc, got.top, got.call);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected status=%0d pc=%h top=%h call=%h", $time,
                     want.status, want.npc, want.top, want.call);
            $display("%0t:          actual   status=%0d pc=%h top=%h call=%h", $time,
                     got.status, got.npc, got.top, got.call);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sbe_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;
  int fail_count, pending, words_checked;
  int words_sent;
  bit long_hold_done;

  stack_bytecode_execute_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  sbe_checker u_chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic send_word(logic [5:0] kind, logic [7:0] ob, logic [15:0] tgt,
                           logic [31:0] imm);
    int gap;
    s_axis_tuser <= kind;
    s_axis_tdata <= {imm, tgt, ob};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    gap = (words_sent > 250 && words_sent < 300) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_imm();
    if ($urandom_range(0, 1)) return $urandom;
    return $urandom_range(0, 20) - 10;
  endfunction

  task automatic send_random(logic [5:0] kind);
    send_word(kind, 8'($urandom), 16'($urandom), rand_imm());
  endtask

  // for loop with a small limit and step, then three to ten next steps
  task automatic run_loop();
    int step, n;
    logic [7:0] var_idx;
    var_idx = 8'($urandom);
    step = $urandom_range(0, 1) ? $urandom_range(1, 3) : -$urandom_range(1, 3);
    send_word(OP_PUSH_NUM, 8'($urandom), 16'($urandom), step > 0 ? 5 : -5);
    send_word(OP_POP_GLB, var_idx, 16'($urandom), $urandom);
    send_word(OP_FOR, 8'($urandom), 16'($urandom), $urandom);
    send_word(OP_PUSH_NUM, 8'($urandom), 16'($urandom), step > 0 ? 12 : -12);
    send_word(OP_PUSH_NUM, 8'($urandom), 16'($urandom), step);
    n = $urandom_range(3, 10);
    repeat (n) send_word(OP_NEXT, var_idx, 16'($urandom), $urandom);
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int gap, hold;
    m_axis_tready = 1'b0;
    long_hold_done = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!long_hold_done && words_sent >= 150) begin
        long_hold_done = 1;
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (words_sent > 250 && words_sent < 300) begin
        m_axis_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
          @(posedge clk);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int r;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    words_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_PUSH_NUM, 8'h00, 16'h0000, 32'h80000000);
    send_word(OP_PUSH_NUM, 8'hff, 16'hffff, 32'hffffffff);
    send_word(OP_DIV, 8'h00, 16'h0000, 32'h0);
    send_word(OP_PUSH_NUM, 8'h00, 16'h0000, 32'h80000000);
    send_word(OP_PUSH_NUM, 8'h00, 16'h0000, 32'hffffffff);
    send_word(OP_MOD, 8'h00, 16'h0000, 32'h0);
    send_word(OP_PUSH_NUM, 8'h00, 16'h0000, 32'h7fffffff);
    send_word(OP_PUSH_NUM, 8'h00, 16'h0000, 32'h0);
    send_word(OP_DIV, 8'h00, 16'h0000, 32'h0);
    send_word(OP_PUSH_NUM, 8'h00, 16'h0000, 32'd0);
    send_word(OP_MOD, 8'h00, 16'h0000, 32'h0);
    send_word(OP_PUSH_NUM, 8'h00, 16'h0000, 32'h7fffffff);
    send_word(OP_INC_GLB, 8'hff, 16'h0000, 32'h0);
    send_word(OP_DEC_GLB, 8'h00, 16'h0000, 32'h0);
    send_word(OP_PUSH_STR, 8'hff, 16'h0000, 32'h0);
    send_word(OP_GOTO, 8'h00, 16'hfffe, 32'h0);
    send_word(OP_GOSUB, 8'h00, 16'h1234, 32'h0);
    send_word(6'd45, 8'h00, 16'h0000, 32'h0);
    send_word(6'd63, 8'hff, 16'hffff, 32'hffffffff);
    repeat (9) send_word(OP_FOR, 8'h00, 16'h0000, 32'h0);
    send_word(OP_XCALL, 8'ha5, 16'h0000, 32'h0);
    send_word(OP_BREAK, 8'h00, 16'hbeef, 32'h0);
    send_word(OP_END, 8'h00, 16'h0000, 32'h0);
    for (int k = 0; k <= 44; k++) send_random(k[5:0]);

    while (words_sent < 430) begin
      r = $urandom_range(0, 99);
      if (r < 15) run_loop();
      else if (r < 22) send_random(6'($urandom_range(45, 63)));
      else send_random(6'($urandom_range(0, 44)));
    end

    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("ran %0d words through the unit, %0d results checked", words_sent,
             words_checked);
    $display("covered all opcodes, unknown codes, divide corners, loops and a long stall");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", pending);
    $display("FAILURE");
    $finish;
  end

endmodule
